// ===== sv/idsc_pkg.sv =====
`default_nettype none

package idsc_pkg;

    typedef enum logic [2:0] {
        CMD_BEGIN = 3'd0,
        CMD_CHUNK = 3'd1,
        CMD_END   = 3'd2,
        CMD_ABORT = 3'd3,
        CMD_TICK  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        STS_READY      = 4'd0,
        STS_ACK        = 4'd1,
        STS_COMMITTING = 4'd2,
        STS_REBOOTING  = 4'd3,
        STS_ABORTED    = 4'd4,
        STS_BAD_PAYLD  = 4'd5,
        STS_BEGIN_FAIL = 4'd6,
        STS_WRITE_FAIL = 4'd7,
        STS_END_FAIL   = 4'd8,
        STS_SIZE_MISM  = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        SS_IDLE       = 3'd0,
        SS_READY      = 3'd1,
        SS_RECEIVING  = 3'd2,
        SS_COMMITTING = 3'd3,
        SS_REBOOTING  = 3'd4
    } t_sess;

    typedef enum logic [1:0] {
        CFG_ACK_WINDOW = 2'd0,
        CFG_MAX_SIZE   = 2'd1,
        CFG_STALL_TMO  = 2'd2
    } t_cfg_idx;

    localparam logic [9:0]  BEGIN_LEN        = 10'd36;
    localparam logic [3:0]  MOTOR_ENERGIZED  = 4'd2;
    localparam logic [6:0]  ACK_WINDOW_RST   = 7'd16;
    localparam logic [23:0] MAX_SIZE_RST     = 24'd3145728;
    localparam logic [15:0] STALL_TMO_RST    = 16'd10000;
    localparam logic [6:0]  WIN_MAX          = 7'h7F;
    localparam logic [16:0] IDLE_TICKS_MAX   = 17'h1FFFF;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  data_len;
        logic [31:0] declared_size;
        logic [3:0]  motor_state;
        logic        flash_ok;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] byte_count;
        logic [2:0]  session_state;
        logic        last;
    } t_out;

    // classified command, as queued between front and back
    typedef struct packed {
        t_cmd        kind;
        logic        bad_len;
        logic        motor_on;
        logic        size_bad;
        logic        len_zero;
        logic [9:0]  len;
        logic [31:0] size;
        logic        ok;
    } t_op;

endpackage

`default_nettype wire

// ===== sv/idsc_front.sv =====
`default_nettype none

module idsc_front (
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire idsc_pkg::t_in   i_in,
    input  wire logic [23:0]     i_max_size,
    output logic                 o_op_valid,
    input  wire logic            i_op_ready,
    output idsc_pkg::t_op        o_op
);
    import idsc_pkg::*;

    logic known;

    always_comb begin
        known = (i_in.cmd == CMD_BEGIN) || (i_in.cmd == CMD_CHUNK) ||
                (i_in.cmd == CMD_END) || (i_in.cmd == CMD_ABORT) ||
                (i_in.cmd == CMD_TICK);

        o_op.kind     = t_cmd'(i_in.cmd);
        o_op.bad_len  = i_in.data_len != BEGIN_LEN;
        o_op.motor_on = i_in.motor_state == MOTOR_ENERGIZED;
        o_op.size_bad = (i_in.declared_size == 32'd0) ||
                        (i_in.declared_size > {8'd0, i_max_size});
        o_op.len_zero = i_in.data_len == 10'd0;
        o_op.len      = i_in.data_len;
        o_op.size     = i_in.declared_size;
        o_op.ok       = i_in.flash_ok;
    end

    // unknown commands are taken and dropped here
    assign o_in_ready = i_op_ready;
    assign o_op_valid = i_in_valid && known;

endmodule

`default_nettype wire

// ===== sv/idsc_queue.sv =====
`default_nettype none

module idsc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire idsc_pkg::t_op  i_push,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output idsc_pkg::t_op       o_pop
);
    import idsc_pkg::*;

    t_op        r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_push_ready = r_cnt != 2'd2;
    assign o_pop_valid  = r_cnt != 2'd0;
    assign o_pop        = r_mem[r_rd];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_push;
    end

endmodule

`default_nettype wire

// ===== sv/idsc_exec.sv =====
`default_nettype none

module idsc_exec (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_op_valid,
    output logic                o_op_ready,
    input  wire idsc_pkg::t_op  i_op,
    input  wire logic [6:0]     i_ack_window,
    input  wire logic [15:0]    i_stall_tmo,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output idsc_pkg::t_out      o_out
);
    import idsc_pkg::*;

    t_sess       r_state,    n_state;
    logic [31:0] r_expected, n_expected;
    logic [31:0] r_rcv,      n_rcv;
    logic [6:0]  r_win,      n_win;
    logic [16:0] r_idle,     n_idle;
    logic        r_out_valid, n_out_valid;
    t_out        r_out,      n_out;
    logic        r_pend_valid, n_pend_valid;
    t_out        r_pend,     n_pend;

    logic        out_ld;
    logic        active;
    logic        clr;
    logic        take;
    logic [32:0] sum;
    logic [31:0] rcv_inc;
    logic [6:0]  win_inc;
    logic [16:0] idle_inc;

    assign out_ld     = !r_out_valid || i_out_ready;
    assign o_op_ready = out_ld && !r_pend_valid;
    assign take       = i_op_valid && o_op_ready;
    assign active     = (r_state == SS_READY) || (r_state == SS_RECEIVING);
    assign sum        = {1'b0, r_rcv} + {23'd0, i_op.len};
    assign rcv_inc    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign win_inc    = (r_win != WIN_MAX) ? r_win + 7'd1 : r_win;
    assign idle_inc   = (r_idle != IDLE_TICKS_MAX) ? r_idle + 17'd1 : r_idle;

    always_comb begin
        n_state      = r_state;
        n_expected   = r_expected;
        n_rcv        = r_rcv;
        n_win        = r_win;
        n_idle       = r_idle;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        clr          = 1'b0;

        if (r_pend_valid) begin
            if (out_ld) begin
                n_out_valid  = 1'b1;
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end
        end else if (take) begin
            case (i_op.kind)
                CMD_BEGIN: begin
                    n_out_valid = 1'b1;
                    n_out = '{STS_BEGIN_FAIL, 32'd0, r_state, 1'b1};
                    if (i_op.bad_len) begin
                        n_out.status = STS_BAD_PAYLD;
                    end else if (i_op.motor_on) begin
                        n_out.status = STS_BEGIN_FAIL;
                    end else if (i_op.size_bad) begin
                        clr = active;
                        if (active) n_out.session_state = SS_IDLE;
                    end else if (!i_op.ok) begin
                        clr = 1'b1;
                        n_out.session_state = SS_IDLE;
                    end else begin
                        n_state    = SS_READY;
                        n_expected = i_op.size;
                        n_rcv      = 32'd0;
                        n_win      = 7'd0;
                        n_idle     = 17'd0;
                        n_out = '{STS_READY, 32'd0, SS_READY, 1'b1};
                    end
                end
                CMD_CHUNK: begin
                    if (!i_op.len_zero && active) begin
                        n_idle = 17'd0;
                        if (!i_op.ok) begin
                            clr = 1'b1;
                            n_out_valid = 1'b1;
                            n_out = '{STS_WRITE_FAIL, r_rcv, SS_IDLE, 1'b1};
                        end else begin
                            n_state = SS_RECEIVING;
                            n_rcv   = rcv_inc;
                            n_win   = win_inc;
                            if (win_inc >= i_ack_window || rcv_inc >= r_expected) begin
                                n_win       = 7'd0;
                                n_out_valid = 1'b1;
                                n_out = '{STS_ACK, rcv_inc, SS_RECEIVING, 1'b1};
                            end
                        end
                    end
                end
                CMD_END: begin
                    n_out_valid = 1'b1;
                    if (!active) begin
                        n_out = '{STS_END_FAIL, r_rcv, r_state, 1'b1};
                    end else if (r_rcv != r_expected) begin
                        clr = 1'b1;
                        n_out = '{STS_SIZE_MISM, r_rcv, SS_IDLE, 1'b1};
                    end else begin
                        n_out = '{STS_COMMITTING, r_rcv, SS_COMMITTING, 1'b0};
                        n_pend_valid = 1'b1;
                        if (!i_op.ok) begin
                            clr = 1'b1;
                            n_pend = '{STS_END_FAIL, r_rcv, SS_IDLE, 1'b1};
                        end else begin
                            n_state = SS_REBOOTING;
                            n_pend = '{STS_REBOOTING, r_rcv, SS_REBOOTING, 1'b1};
                        end
                    end
                end
                CMD_ABORT: begin
                    clr = 1'b1;
                    n_out_valid = 1'b1;
                    n_out = '{STS_ABORTED, 32'd0, SS_IDLE, 1'b1};
                end
                CMD_TICK: begin
                    if (r_state == SS_RECEIVING) begin
                        n_idle = idle_inc;
                        if (idle_inc > {1'b0, i_stall_tmo}) begin
                            clr = 1'b1;
                            n_out_valid = 1'b1;
                            n_out = '{STS_ABORTED, 32'd0, SS_IDLE, 1'b1};
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (clr) begin
            n_state    = SS_IDLE;
            n_expected = 32'd0;
            n_rcv      = 32'd0;
            n_win      = 7'd0;
            n_idle     = 17'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SS_IDLE;
            r_expected   <= 32'd0;
            r_rcv        <= 32'd0;
            r_win        <= 7'd0;
            r_idle       <= 17'd0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_expected   <= n_expected;
            r_rcv        <= n_rcv;
            r_win        <= n_win;
            r_idle       <= n_idle;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== sv/image_download_session_control.sv =====
// Channel  Signals                                   Direction
// -------  ----------------------------------------  -----------
// in       i_in_valid, o_in_ready, i_in (t_in)       command in
// out      o_out_valid, i_out_ready, o_out (t_out)   result out
// cfg      i_cfg_valid, o_cfg_ready, i_cfg_index/data register write
//
// One command item per cycle while the queue has room and the receiver takes results;
// an end reaching commit holds execute until its pending outcome reaches the output,
// so its two results leave in order. Results leave from a registered execute output.
// A two-entry queue separates classify and execute; each stalls on its own.
// Synchronous active-low reset: idle session, registers at their defaults.
`default_nettype none

module image_download_session_control (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire idsc_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output idsc_pkg::t_out      o_out,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [23:0]    i_cfg_data
);
    import idsc_pkg::*;

    logic [6:0]  r_ack_window;
    logic [23:0] r_max_size;
    logic [15:0] r_stall_tmo;

    logic f_valid, f_ready;
    t_op  f_op;
    logic q_valid, q_ready;
    t_op  q_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_window <= ACK_WINDOW_RST;
            r_max_size   <= MAX_SIZE_RST;
            r_stall_tmo  <= STALL_TMO_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACK_WINDOW: r_ack_window <= i_cfg_data[6:0];
                CFG_MAX_SIZE:   r_max_size   <= i_cfg_data;
                CFG_STALL_TMO:  r_stall_tmo  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    idsc_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_max_size (r_max_size),
        .o_op_valid (f_valid),
        .i_op_ready (f_ready),
        .o_op       (f_op)
    );

    idsc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push       (f_op),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop        (q_op)
    );

    idsc_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (q_valid),
        .o_op_ready   (q_ready),
        .i_op         (q_op),
        .i_ack_window (r_ack_window),
        .i_stall_tmo  (r_stall_tmo),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

`ifndef SYNTHESIS
    a_mid_is_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> o_out.status == STS_COMMITTING &&
        o_out.session_state == SS_COMMITTING)
        else $error("non-final result is not committing");

    a_commit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last |=> o_out_valid &&
        (o_out.status == STS_REBOOTING || o_out.status == STS_END_FAIL))
        else $error("commit not followed by its outcome");

    a_abort_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == STS_ABORTED |->
        o_out.byte_count == 32'd0 && o_out.session_state == SS_IDLE)
        else $error("abort result carries stale session");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import idsc_pkg::*;

    typedef struct packed {
        t_in  item;
        logic hand;
        t_out want;
    } row_t;

    localparam t_out NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_item = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out        o_out;
    logic        o_cfg_ready;

    // session model
    t_sess       m_sess;
    logic [31:0] m_total;
    logic [31:0] m_rcvd;
    logic [6:0]  m_win;
    logic [16:0] m_idle;
    logic [6:0]  cfg_ack_win;
    logic [23:0] cfg_max_size;
    logic [15:0] cfg_stall;

    t_out        due_results[$];
    t_out        head;
    int          fail_count = 0;
    int          useful_items = 0;
    int          snd_pct = 0;
    int          rcv_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    row_t dir_plan [25] = '{
        {{CMD_BEGIN, 10'd35, 32'd100, 4'd0, 1'b1}, 1'b1, {STS_BAD_PAYLD, 32'd0, SS_IDLE, 1'b1}},
        {{CMD_BEGIN, BEGIN_LEN, 32'd100, MOTOR_ENERGIZED, 1'b1}, 1'b1,
            {STS_BEGIN_FAIL, 32'd0, SS_IDLE, 1'b1}},
        {{CMD_BEGIN, BEGIN_LEN, 32'd0, 4'd0, 1'b1}, 1'b1,
            {STS_BEGIN_FAIL, 32'd0, SS_IDLE, 1'b1}},
        {{CMD_BEGIN, BEGIN_LEN, 32'd3145729, 4'd0, 1'b1}, 1'b1,
            {STS_BEGIN_FAIL, 32'd0, SS_IDLE, 1'b1}},
        {{CMD_BEGIN, BEGIN_LEN, 32'd100, 4'd0, 1'b0}, 1'b1,
            {STS_BEGIN_FAIL, 32'd0, SS_IDLE, 1'b1}},
        {{CMD_END, 10'd0, 32'd0, 4'd0, 1'b1}, 1'b1, {STS_END_FAIL, 32'd0, SS_IDLE, 1'b1}},
        {{CMD_CHUNK, 10'd512, 32'd0, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{CMD_TICK, 10'd0, 32'd0, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{3'd7, 10'h3FF, 32'hFFFF_FFFF, 4'hF, 1'b1}, 1'b0, NO_RES},
        {{3'd5, 10'd0, 32'd0, 4'd0, 1'b0}, 1'b0, NO_RES},
        {{CMD_BEGIN, BEGIN_LEN, 32'd3145728, 4'hF, 1'b1}, 1'b1,
            {STS_READY, 32'd0, SS_READY, 1'b1}},
        {{CMD_CHUNK, 10'd0, 32'd0, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{CMD_CHUNK, 10'h3FF, 32'd0, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{CMD_TICK, 10'd0, 32'd0, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{CMD_CHUNK, 10'd7, 32'd0, 4'd0, 1'b0}, 1'b1, {STS_WRITE_FAIL, 32'd1023, SS_IDLE, 1'b1}},
        {{CMD_BEGIN, BEGIN_LEN, 32'd100, 4'd0, 1'b1}, 1'b1, {STS_READY, 32'd0, SS_READY, 1'b1}},
        {{CMD_BEGIN, BEGIN_LEN, 32'd0, 4'd0, 1'b1}, 1'b1,
            {STS_BEGIN_FAIL, 32'd0, SS_IDLE, 1'b1}},
        {{CMD_BEGIN, BEGIN_LEN, 32'd100, 4'd1, 1'b1}, 1'b1, {STS_READY, 32'd0, SS_READY, 1'b1}},
        {{CMD_CHUNK, 10'd100, 32'd0, 4'd0, 1'b1}, 1'b1,
            {STS_ACK, 32'd100, SS_RECEIVING, 1'b1}},
        {{CMD_END, 10'd0, 32'd0, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{CMD_END, 10'd0, 32'd0, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{CMD_BEGIN, BEGIN_LEN, 32'd4, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{CMD_CHUNK, 10'd4, 32'd0, 4'd0, 1'b1}, 1'b0, NO_RES},
        {{CMD_END, 10'd0, 32'd0, 4'd0, 1'b0}, 1'b0, NO_RES},
        {{CMD_ABORT, 10'd0, 32'd0, 4'd0, 1'b1}, 1'b1, {STS_ABORTED, 32'd0, SS_IDLE, 1'b1}}
    };

    image_download_session_control dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic void drop_session();
        m_sess  = SS_IDLE;
        m_total = '0;
        m_rcvd  = '0;
        m_win   = '0;
        m_idle  = '0;
    endfunction

    function automatic int emit(input t_status st, input logic [31:0] bc, input t_sess ss,
                                input logic fin);
        due_results.push_back({st, bc, ss, fin});
        return 1;
    endfunction

    // returns the number of results the item causes
    function automatic int session_step(input t_in it);
        logic [31:0] got;
        logic        active;
        active = (m_sess == SS_READY) || (m_sess == SS_RECEIVING);
        got = m_rcvd;
        case (it.cmd)
            CMD_BEGIN: begin
                if (it.data_len != BEGIN_LEN)
                    return emit(STS_BAD_PAYLD, '0, m_sess, 1'b1);
                if (it.motor_state == MOTOR_ENERGIZED)
                    return emit(STS_BEGIN_FAIL, '0, m_sess, 1'b1);
                if (active)
                    drop_session();
                if (it.declared_size == '0 || it.declared_size > {8'd0, cfg_max_size})
                    return emit(STS_BEGIN_FAIL, '0, m_sess, 1'b1);
                m_total = it.declared_size;
                m_rcvd  = '0;
                m_win   = '0;
                if (!it.flash_ok) begin
                    drop_session();
                    return emit(STS_BEGIN_FAIL, '0, m_sess, 1'b1);
                end
                m_sess = SS_READY;
                m_idle = '0;
                return emit(STS_READY, '0, m_sess, 1'b1);
            end
            CMD_CHUNK: begin
                if (it.data_len == '0 || !active)
                    return 0;
                m_sess = SS_RECEIVING;
                m_idle = '0;
                if (!it.flash_ok) begin
                    drop_session();
                    return emit(STS_WRITE_FAIL, got, m_sess, 1'b1);
                end
                if (m_rcvd > 32'hFFFF_FFFF - {22'd0, it.data_len})
                    m_rcvd = 32'hFFFF_FFFF;
                else
                    m_rcvd = m_rcvd + {22'd0, it.data_len};
                if (m_win < WIN_MAX)
                    m_win = m_win + 7'd1;
                if (m_win >= cfg_ack_win || m_rcvd >= m_total) begin
                    m_win = '0;
                    return emit(STS_ACK, m_rcvd, m_sess, 1'b1);
                end
                return 0;
            end
            CMD_END: begin
                if (!active)
                    return emit(STS_END_FAIL, got, m_sess, 1'b1);
                if (got != m_total) begin
                    drop_session();
                    return emit(STS_SIZE_MISM, got, m_sess, 1'b1);
                end
                void'(emit(STS_COMMITTING, got, SS_COMMITTING, 1'b0));
                if (!it.flash_ok) begin
                    drop_session();
                    void'(emit(STS_END_FAIL, got, m_sess, 1'b1));
                    return 2;
                end
                m_sess = SS_REBOOTING;
                void'(emit(STS_REBOOTING, got, m_sess, 1'b1));
                return 2;
            end
            CMD_ABORT: begin
                drop_session();
                return emit(STS_ABORTED, '0, m_sess, 1'b1);
            end
            CMD_TICK: begin
                if (m_sess != SS_RECEIVING)
                    return 0;
                if (m_idle < IDLE_TICKS_MAX)
                    m_idle = m_idle + 17'd1;
                if (m_idle > {1'b0, cfg_stall}) begin
                    drop_session();
                    return emit(STS_ABORTED, '0, m_sess, 1'b1);
                end
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // returns with valid still high; the next call replaces the item or lowers valid
    task automatic send_item(input t_in it, input logic hand, input t_out hand_res);
        t_sess       s0;
        logic [31:0] r0;
        logic [16:0] i0;
        logic [6:0]  w0;
        int          n;
        int          gap;
        gap = 0;
        while ($urandom_range(99, 0) < snd_pct)
            gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        s0 = m_sess;
        r0 = m_rcvd;
        i0 = m_idle;
        w0 = m_win;
        n = session_step(it);
        if (hand) begin
            repeat (n) void'(due_results.pop_back());
            due_results.push_back(hand_res);
        end
        if (n != 0 || s0 != m_sess || r0 != m_rcvd || i0 != m_idle || w0 != m_win)
            useful_items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_ACK_WINDOW: cfg_ack_win = val[6:0];
            CFG_MAX_SIZE:   cfg_max_size = val;
            CFG_STALL_TMO:  cfg_stall = val[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [23:0] ack, input logic [23:0] max_sz,
                             input logic [23:0] stall);
        write_reg(CFG_ACK_WINDOW, ack);
        write_reg(CFG_MAX_SIZE, max_sz);
        write_reg(CFG_STALL_TMO, stall);
    endtask

    task automatic run_session();
        logic [31:0] cap;
        logic [31:0] size;
        logic [31:0] sent;
        logic [9:0]  len;
        logic [3:0]  motor;
        int          streak;
        int          pick;
        cap = (cfg_max_size == '0) ? 32'd1 :
              (cfg_max_size < 24'd1500) ? {8'd0, cfg_max_size} : 32'd1500;
        size = $urandom_range(cap, 1);
        motor = 4'($urandom_range(15, 0));
        if (motor == MOTOR_ENERGIZED && chance(85))
            motor = 4'd0;
        send_item({CMD_BEGIN, BEGIN_LEN, size, motor, chance(97)}, 1'b0, NO_RES);
        sent = '0;
        while (sent < size && (m_sess == SS_READY || m_sess == SS_RECEIVING) && chance(97)) begin
            if (chance(10)) begin
                streak = (cfg_stall <= 16'd40) ? $urandom_range(cfg_stall + 2, 1)
                                               : $urandom_range(3, 1);
                repeat (streak)
                    send_item({CMD_TICK, 10'($urandom), $urandom, 4'($urandom), 1'($urandom)},
                              1'b0, NO_RES);
            end
            len = chance(50) ? 10'($urandom_range(64, 1)) : 10'($urandom_range(512, 1));
            if ({22'd0, len} > size - sent && chance(75))
                len = 10'(size - sent);
            send_item({CMD_CHUNK, len, $urandom, 4'($urandom), chance(98)}, 1'b0, NO_RES);
            sent = sent + {22'd0, len};
        end
        pick = $urandom_range(19, 0);
        if (pick < 17)
            send_item({CMD_END, 10'($urandom), $urandom, 4'($urandom), chance(95)},
                      1'b0, NO_RES);
        else if (pick < 19)
            send_item({CMD_ABORT, 10'($urandom), $urandom, 4'($urandom), 1'($urandom)},
                      1'b0, NO_RES);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 1))
            send_item({3'($urandom_range(7, 0)), 10'($urandom), $urandom, 4'($urandom),
                       1'($urandom)}, 1'b0, NO_RES);
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    // receiver side: random stalls, plus a counted hold-off on request
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99, 0) >= rcv_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected item, status %0d byte_count %0d state %0d last %0d",
                         $time, o_out.status, o_out.byte_count, o_out.session_state,
                         o_out.last);
                fail_count++;
            end else begin
                head = due_results.pop_front();
                if (o_out.status !== head.status)
                    report("status", head.status, o_out.status);
                if (o_out.byte_count !== head.byte_count)
                    report("byte_count", head.byte_count, o_out.byte_count);
                if (o_out.session_state !== head.session_state)
                    report("session_state", head.session_state, o_out.session_state);
                if (o_out.last !== head.last)
                    report("last", head.last, o_out.last);
            end
        end
    end

    initial begin
        cfg_ack_win  = ACK_WINDOW_RST;
        cfg_max_size = MAX_SIZE_RST;
        cfg_stall    = STALL_TMO_RST;
        drop_session();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_plan[k])
            send_item(dir_plan[k].item, dir_plan[k].hand, dir_plan[k].want);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                1: configure(24'd1, 24'hFF_FFFF, 24'd1);
                2: configure(24'd64, 24'd1, 24'hFFFF);
                3: configure(24'd0, 24'd1200, 24'd0);
                4: configure(24'd127, 24'd900, 24'd25);
                5: configure(24'($urandom), 24'($urandom), 24'($urandom));
                6, 7: configure(24'($urandom_range(8, 1)), 24'($urandom_range(5000, 1)),
                                24'($urandom_range(30, 1)));
                default: ;
            endcase
            case (ph % 4)
                0: begin snd_pct = 0;  rcv_pct = 0;  end
                1: begin snd_pct = 74; rcv_pct = 0;  end
                2: begin snd_pct = 0;  rcv_pct = 74; end
                default: begin snd_pct = 38; rcv_pct = 38; end
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            useful_items = 0;
            while (useful_items < 250) begin
                if (chance(80))
                    run_session();
                else
                    send_noise();
            end
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
